### rtl/dffe_pkg.sv
// ----------------------------------------------------------------------------
// dffe_pkg
// Shared types, constants and tables of the director field energy block.
// ----------------------------------------------------------------------------
package dffe_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned FIELD_W        = 16;
  localparam int unsigned COEF_W         = 16;
  localparam int unsigned ENERGY_W       = 42;
  localparam int unsigned TOTAL_W        = 63;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CORDIC_STEPS   = 16;
  localparam int unsigned STEP_W         = 4;
  localparam int unsigned ANG_IDX_W      = 3;
  localparam int unsigned NUM_ANGLES     = 5;
  localparam int unsigned SQ_IDX_W       = 3;
  localparam int unsigned NUM_SQ         = 8;
  localparam int unsigned SCL_IDX_W      = 2;
  localparam int unsigned NUM_SCL        = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPLAY_COEF = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BEND_COEF  = CFG_IDX_W'(1);

  localparam logic [COEF_W-1:0] SPLAY_COEF_RST = COEF_W'(256);
  localparam logic [COEF_W-1:0] BEND_COEF_RST  = COEF_W'(256);

  // cordic datapath
  localparam int unsigned CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032875);

  typedef struct packed {
    logic [FIELD_W-1:0] center_angle;
    logic [FIELD_W-1:0] left_angle;
    logic [FIELD_W-1:0] right_angle;
    logic [FIELD_W-1:0] down_angle;
    logic [FIELD_W-1:0] up_angle;
    logic               cell_locked;
    logic               last_cell;
  } in_item_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] cell_energy;
    logic [TOTAL_W-1:0]  energy_total;
    logic                total_done;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROT,
    ST_STORE,
    ST_SQ,
    ST_SCALE,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic                 load;
    logic                 cinit;
    logic                 cstep;
    logic                 cstore;
    logic [ANG_IDX_W-1:0] ang;
    logic [STEP_W-1:0]    stp;
    logic                 sq;
    logic [SQ_IDX_W-1:0]  sqi;
    logic                 scl;
    logic [SCL_IDX_W-1:0] scli;
    logic                 fin;
  } dp_cmd_t;

  typedef struct packed {
    logic locked;
    logic out_free;
  } dp_sts_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [CW-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic signed [CW-1:0] r;
    case (i)
      4'd0:    r = CW'(536870912);
      4'd1:    r = CW'(316933406);
      4'd2:    r = CW'(167458907);
      4'd3:    r = CW'(85004756);
      4'd4:    r = CW'(42667331);
      4'd5:    r = CW'(21354465);
      4'd6:    r = CW'(10679838);
      4'd7:    r = CW'(5340245);
      4'd8:    r = CW'(2670163);
      4'd9:    r = CW'(1335087);
      4'd10:   r = CW'(667544);
      4'd11:   r = CW'(333772);
      4'd12:   r = CW'(166886);
      4'd13:   r = CW'(83443);
      4'd14:   r = CW'(41722);
      default: r = CW'(20861);
    endcase
    return r;
  endfunction

endpackage

### rtl/dffe_ctrl.sv
// ----------------------------------------------------------------------------
// dffe_ctrl
// Sequencer: five cordic passes, eight squares, four scale products, result; a locked cell goes straight to the result.
// ----------------------------------------------------------------------------
module dffe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output dffe_pkg::dp_cmd_t cmd_o,
  input  dffe_pkg::dp_sts_t sts_i
);
  import dffe_pkg::*;

  ctrl_state_e          state_q, state_d;
  logic [ANG_IDX_W-1:0] ang_q, ang_d;
  logic [STEP_W-1:0]    stp_q, stp_d;
  logic [SQ_IDX_W-1:0]  sqi_q, sqi_d;
  logic [SCL_IDX_W-1:0] scli_q, scli_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ang_q   <= '0;
      stp_q   <= '0;
      sqi_q   <= '0;
      scli_q  <= '0;
    end else begin
      state_q <= state_d;
      ang_q   <= ang_d;
      stp_q   <= stp_d;
      sqi_q   <= sqi_d;
      scli_q  <= scli_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    ang_d   = ang_q;
    stp_d   = stp_q;
    sqi_d   = sqi_q;
    scli_d  = scli_q;
    cmd_o      = '0;
    cmd_o.ang  = ang_q;
    cmd_o.stp  = stp_q;
    cmd_o.sqi  = sqi_q;
    cmd_o.scli = scli_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          ang_d      = '0;
          state_d    = ST_INIT;
        end
      end
      ST_INIT: begin
        if (sts_i.locked) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.cinit = 1'b1;
          stp_d       = '0;
          state_d     = ST_ROT;
        end
      end
      ST_ROT: begin
        cmd_o.cstep = 1'b1;
        stp_d       = stp_q + 1'b1;
        if (stp_q == STEP_W'(CORDIC_STEPS - 1)) state_d = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.cstore = 1'b1;
        if (ang_q == ANG_IDX_W'(NUM_ANGLES - 1)) begin
          sqi_d   = '0;
          state_d = ST_SQ;
        end else begin
          ang_d   = ang_q + 1'b1;
          state_d = ST_INIT;
        end
      end
      ST_SQ: begin
        cmd_o.sq = 1'b1;
        sqi_d    = sqi_q + 1'b1;
        if (sqi_q == SQ_IDX_W'(NUM_SQ - 1)) begin
          scli_d  = '0;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scl = 1'b1;
        scli_d    = scli_q + 1'b1;
        if (scli_q == SCL_IDX_W'(NUM_SCL - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/dffe_dp.sv
// ----------------------------------------------------------------------------
// dffe_dp
// Datapath: folding, shared cordic, shared multiplier, energy and total.
// ----------------------------------------------------------------------------
module dffe_dp #(
  parameter int unsigned ANGLE_BITS = dffe_pkg::ANGLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dffe_pkg::in_item_t             in_item_i,
  input  logic                           cfg_we_i,
  input  logic [dffe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dffe_pkg::COEF_W-1:0]    cfg_data_i,
  input  dffe_pkg::dp_cmd_t              cmd_i,
  output dffe_pkg::dp_sts_t              sts_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dffe_pkg::out_item_t            out_item_o
);
  import dffe_pkg::*;

  localparam int unsigned AB = ANGLE_BITS;
  localparam logic [AB-1:0] QTR = AB'(1) << (AB - 2);
  localparam logic [AB:0]   QTR3 = (AB + 1)'(3) * (AB + 1)'(QTR);
  localparam int unsigned QW = 17;   // q15 value with sign, +-1.0
  localparam int unsigned DW = 18;   // difference
  localparam int unsigned TW = 19;   // splay or bend term
  localparam int unsigned SW = 37;   // sum of four squares
  localparam int unsigned MW = 21;   // multiplier operand
  localparam int unsigned EW = 56;   // weighted sum before the shift
  localparam int unsigned CHUNK = 20;

  logic [COEF_W-1:0] splay_coef_q, bend_coef_q;
  in_item_t          item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      splay_coef_q <= SPLAY_COEF_RST;
      bend_coef_q  <= BEND_COEF_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_SPLAY_COEF) splay_coef_q <= cfg_data_i;
      if (cfg_index_i == CFG_BEND_COEF)  bend_coef_q  <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
  end

  assign sts_o.locked = item_q.cell_locked;

  // angle selection and head-tail folding
  logic [AB-1:0] ctr_a, nb_a, diff_a, sel_a;

  function automatic logic [AB-1:0] trim(input logic [FIELD_W-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    return e[AB-1:0];
  endfunction

  always_comb begin
    ctr_a = trim(item_q.center_angle);
    case (cmd_i.ang)
      3'd1:    nb_a = trim(item_q.left_angle);
      3'd2:    nb_a = trim(item_q.right_angle);
      3'd3:    nb_a = trim(item_q.down_angle);
      default: nb_a = trim(item_q.up_angle);
    endcase
    diff_a = nb_a - ctr_a;
    if (cmd_i.ang == '0) begin
      sel_a = ctr_a;
    end else if (diff_a > QTR && (AB + 1)'(diff_a) < QTR3) begin
      sel_a = nb_a + (QTR << 1);
    end else begin
      sel_a = nb_a;
    end
  end

  // cordic, one step a cycle
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic                 flip_q;
  logic [31:0]          ph, ph_f;
  logic                 flip;
  logic signed [CW-1:0] dx, dy, at;

  always_comb begin
    ph   = 32'(sel_a) << (32 - AB);
    flip = ph[31] ^ ph[30];
    ph_f = {ph[31] ^ flip, ph[30:0]};
    dx   = y_q >>> cmd_i.stp;
    dy   = x_q >>> cmd_i.stp;
    at   = atan_lut(cmd_i.stp);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cinit) begin
      x_q    <= CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= CW'($signed(ph_f));
      flip_q <= flip;
    end else if (cmd_i.cstep) begin
      if (!z_q[CW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  function automatic logic signed [QW-1:0] to_q15(input logic signed [CW-1:0] v,
                                                 input logic neg);
    logic signed [CW-1:0] t;
    logic signed [QW-1:0] r;
    t = (v + CW'(16384)) >>> 15;
    if (t > CW'(32768))       r = QW'(32768);
    else if (t < -CW'(32768)) r = -QW'(32768);
    else                      r = t[QW-1:0];
    return neg ? -r : r;
  endfunction

  logic signed [QW-1:0] s_q [NUM_ANGLES];
  logic signed [QW-1:0] c_q [NUM_ANGLES];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cstore) begin
      s_q[cmd_i.ang] <= to_q15(y_q, flip_q);
      c_q[cmd_i.ang] <= to_q15(x_q, flip_q);
    end
  end

  // differences to the center: 1 left, 2 right, 3 down, 4 up
  logic signed [DW-1:0] ds [1:4];
  logic signed [DW-1:0] dc [1:4];
  always_comb begin
    for (int k = 1; k < 5; k++) begin
      ds[k] = DW'(s_q[k]) - DW'(s_q[0]);
      dc[k] = DW'(c_q[k]) - DW'(c_q[0]);
    end
  end

  logic signed [TW-1:0] term;
  always_comb begin
    case (cmd_i.sqi)
      3'd0:    term = TW'(dc[2]) + TW'(ds[4]);
      3'd1:    term = TW'(dc[1]) + TW'(ds[4]);
      3'd2:    term = TW'(dc[2]) + TW'(ds[3]);
      3'd3:    term = TW'(dc[1]) + TW'(ds[3]);
      3'd4:    term = TW'(ds[1]) - TW'(dc[4]);
      3'd5:    term = TW'(ds[2]) - TW'(dc[4]);
      3'd6:    term = TW'(ds[1]) - TW'(dc[3]);
      default: term = TW'(ds[2]) - TW'(dc[3]);
    endcase
  end

  // shared multiplier: squares, then coefficient times 20-bit chunks
  logic [SW-1:0]        splay_q, bend_q;
  logic [EW-1:0]        esum_q;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [2*MW-1:0] prod;
  logic [COEF_W-1:0]    coef;
  logic [SW-1:0]        src;
  logic [CHUNK-1:0]     chunk;
  logic [EW-1:0]        part;

  always_comb begin
    coef  = cmd_i.scli[1] ? bend_coef_q : splay_coef_q;
    src   = cmd_i.scli[1] ? bend_q : splay_q;
    chunk = cmd_i.scli[0] ? CHUNK'(src[SW-1:CHUNK]) : src[CHUNK-1:0];
    if (cmd_i.sq) begin
      mul_a = MW'(term);
      mul_b = MW'(term);
    end else begin
      mul_a = MW'({1'b0, coef});
      mul_b = MW'({1'b0, chunk});
    end
    prod = mul_a * mul_b;
    part = EW'(prod[COEF_W+CHUNK-1:0]) << (cmd_i.scli[0] ? CHUNK : 0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      splay_q <= '0;
      bend_q  <= '0;
      esum_q  <= '0;
    end else if (cmd_i.sq) begin
      if (!cmd_i.sqi[2]) splay_q <= splay_q + prod[SW-1:0];
      else               bend_q  <= bend_q + prod[SW-1:0];
    end else if (cmd_i.scl) begin
      esum_q <= esum_q + part;
    end
  end

  // energy, saturating total and the output register
  logic [EW-9:0]      eshift;
  logic [ENERGY_W-1:0] energy;
  logic [TOTAL_W:0]    tsum;
  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W-1:0]  acc_q;
  logic                out_valid_q;
  out_item_t           out_q;

  always_comb begin
    eshift = esum_q[EW-1:8];
    if (item_q.cell_locked)              energy = '0;
    else if (|eshift[EW-9:ENERGY_W])     energy = '1;
    else                                 energy = eshift[ENERGY_W-1:0];
    tsum  = (TOTAL_W + 1)'(acc_q) + (TOTAL_W + 1)'(energy);
    total = tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.fin) begin
        acc_q       <= item_q.last_cell ? '0 : total;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_q.cell_energy  <= energy;
      out_q.energy_total <= total;
      out_q.total_done   <= item_q.last_cell;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### rtl/director_field_frank_energy.sv
// ----------------------------------------------------------------------------
// director_field_frank_energy
// Splay and bend elastic energy of a 2D director field, one cell per beat,
// with a saturating grid total.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_item_t (five angles, flags)
//  out      output     out_valid / out_stall out_item_t (energy, total, done)
//  cfg      input      cfg_valid / cfg_ready index and 16-bit coefficient
//
//  an unlocked cell runs the accept state, five cordic passes on one shared
//  rotator, eight squares and four scale products on one shared multiplier,
//  then the result state; a locked cell goes from init straight to the result
//  the finished beat sits in the output register, so a new cell is taken
//  while the previous result is stalled
//  reset clears the total and sets both coefficients to 1.0
// ----------------------------------------------------------------------------
module director_field_frank_energy #(
  parameter int unsigned ANGLE_BITS = dffe_pkg::ANGLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dffe_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dffe_pkg::out_item_t            out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dffe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dffe_pkg::COEF_W-1:0]    cfg_data_i
);
  import dffe_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  dffe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  dffe_dp #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
